// ===== rtl/core/soq_pkg.sv =====
// Shared types, widths and codes for the sorted open-set queue.
// No dependencies; every other file of the block but soq_ram imports this package.
package soq_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam int CMD_W    = 2;
    localparam int COORD_W  = 8;
    localparam int KEY_W    = 16;
    localparam int COST_W   = 24;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int CFG_W    = 9;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(256);

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_POP    = 2'd1;
    localparam cmd_t CMD_UPDATE = 2'd2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // One stored entry of the open set.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [KEY_W-1:0]   key;
        logic [COST_W-1:0]  cost;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    ins_init;
        logic    bis_issue;
        logic    bis_cmp;
        logic    shu_init;
        logic    shu_step;
        logic    scan_init;
        logic    scan_step;
        logic    scan_take;
        logic    shd_step;
        logic    pop_issue;
        logic    pop_take;
        logic    st_en;
        status_t st_code;
        logic    out_load;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic bis_more;
        logic shu_done;
        logic scan_hit;
        logic scan_miss;
        logic shd_done;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/core/soq_if.sv =====
// Valid/ready channel interfaces for items, results and the limit register.
// Depends on soq_pkg for the field widths.
interface soq_in_if;
    import soq_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [KEY_W-1:0]   node_key;
    logic [COST_W-1:0]  total_cost;

    modport source (output valid, command, pos_x, pos_y, node_key, total_cost, input ready);
    modport sink (input valid, command, pos_x, pos_y, node_key, total_cost, output ready);
endinterface

interface soq_out_if;
    import soq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [KEY_W-1:0]    out_key;
    logic [COST_W-1:0]   out_cost;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, out_x, out_y, out_key, out_cost, entry_count,
                    input ready);
    modport sink (input valid, status, out_x, out_y, out_key, out_cost, entry_count,
                  output ready);
endinterface

interface soq_cfg_if;
    import soq_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] capacity_limit;

    modport source (output valid, capacity_limit, input ready);
    modport sink (input valid, capacity_limit, output ready);
endinterface

// ===== rtl/core/soq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module soq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/soq_ctrl.sv =====
// Controller state machine of the sorted open-set queue.
// Depends on soq_pkg for the command and status structs and the codes.
module soq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output soq_pkg::dp_cmd_t cmd,
    input  soq_pkg::dp_sts_t sts
);
    import soq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DECODE   = 11'b000_0000_0010,
        S_INS_CHK  = 11'b000_0000_0100,
        S_BIS      = 11'b000_0000_1000,
        S_BIS_CMP  = 11'b000_0001_0000,
        S_SHIFT_UP = 11'b000_0010_0000,
        S_POP_RD   = 11'b000_0100_0000,
        S_POP_WAIT = 11'b000_1000_0000,
        S_SCAN     = 11'b001_0000_0000,
        S_SHIFT_DN = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.cmd)
                    CMD_INSERT:
                    begin
                        state_next = S_INS_CHK;
                    end
                    CMD_POP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.st_en   = 1'b1;
                            cmd.st_code = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_POP_RD;
                        end
                    end
                    CMD_UPDATE:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_INS_CHK:
            begin
                if (sts.full)
                begin
                    cmd.st_en   = 1'b1;
                    cmd.st_code = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.ins_init = 1'b1;
                    state_next   = S_BIS;
                end
            end
            S_BIS:
            begin
                if (sts.bis_more)
                begin
                    cmd.bis_issue = 1'b1;
                    state_next    = S_BIS_CMP;
                end
                else
                begin
                    cmd.shu_init = 1'b1;
                    state_next   = S_SHIFT_UP;
                end
            end
            S_BIS_CMP:
            begin
                cmd.bis_cmp = 1'b1;
                state_next  = S_BIS;
            end
            S_SHIFT_UP:
            begin
                cmd.shu_step = 1'b1;
                if (sts.shu_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_RD:
            begin
                cmd.pop_issue = 1'b1;
                state_next    = S_POP_WAIT;
            end
            S_POP_WAIT:
            begin
                cmd.pop_take = 1'b1;
                state_next   = S_DONE;
            end
            S_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    cmd.scan_take = 1'b1;
                    state_next    = S_SHIFT_DN;
                end
                else if (sts.scan_miss)
                begin
                    state_next = S_INS_CHK;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT_DN:
            begin
                cmd.shd_step = 1'b1;
                if (sts.shd_done)
                begin
                    state_next = S_INS_CHK;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/soq_datapath.sv =====
// Datapath of the sorted open-set queue: entry RAM, pointers, limit and result registers.
// Depends on soq_pkg and soq_ram.
module soq_datapath #(
    parameter int DEPTH = soq_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  soq_pkg::dp_cmd_t             cmd,
    output soq_pkg::dp_sts_t             sts,
    input  logic [soq_pkg::CMD_W-1:0]    in_command,
    input  logic [soq_pkg::COORD_W-1:0]  in_x,
    input  logic [soq_pkg::COORD_W-1:0]  in_y,
    input  logic [soq_pkg::KEY_W-1:0]    in_key,
    input  logic [soq_pkg::COST_W-1:0]   in_cost,
    input  logic                         cfg_we,
    input  logic [soq_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [soq_pkg::STATUS_W-1:0] out_status,
    output soq_pkg::entry_t              out_entry,
    output logic [soq_pkg::COUNT_W-1:0]  out_count
);
    import soq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = ((AW > CFG_W) ? AW : CFG_W) + 1;

    typedef logic [AW-1:0] addr_t;

    // Control state.
    addr_t            count_reg, count_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic [CFG_W-1:0] cap_reg;

    // Working registers.
    addr_t   lo_reg, lo_next;
    addr_t   hi_reg, hi_next;
    addr_t   mid_reg, mid_next;
    addr_t   idx_reg, idx_next;
    addr_t   wptr_reg, wptr_next;
    cmd_t    cmd_reg, cmd_next;
    entry_t  item_reg, item_next;
    status_t status_reg, status_next;
    entry_t  res_reg, res_next;
    status_t out_status_reg, out_status_next;
    entry_t  out_entry_reg, out_entry_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    // RAM ports.
    logic   ram_we;
    addr_t  ram_waddr;
    entry_t ram_wdata;
    logic   ram_re;
    addr_t  ram_raddr;
    entry_t rd_data;

    logic [AW:0]   lohi_sum;
    addr_t         mid;
    logic [AW:0]   idx_inc;
    logic          shd_more;
    logic          scan_more;
    logic          shu_at_slot;
    logic [LW-1:0] eff_limit;

    assign lohi_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = lohi_sum[AW:1];
    assign idx_inc     = {1'b0, idx_reg} + {{AW{1'b0}}, 1'b1};
    assign shd_more    = idx_inc < {1'b0, count_reg};
    assign scan_more   = idx_reg < count_reg;
    assign shu_at_slot = (idx_reg == lo_reg);
    assign eff_limit   = (LW'(cap_reg) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_reg);

    always_comb
    begin
        sts           = '0;
        sts.cmd       = cmd_reg;
        sts.empty     = (count_reg == '0);
        sts.full      = (LW'(count_reg) + LW'(1)) >= eff_limit;
        sts.bis_more  = lo_reg < hi_reg;
        sts.shu_done  = !pend_reg && shu_at_slot;
        sts.scan_hit  = pend_reg && (rd_data.key == item_reg.key);
        sts.scan_miss = !pend_reg && !scan_more;
        sts.shd_done  = !pend_reg && !shd_more;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // RAM access. Shifts run one entry a cycle: the read issued in one cycle is
    // written back one place further on in the next.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pend_reg ? wptr_reg : lo_reg;
        ram_wdata = pend_reg ? rd_data : item_reg;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        if (cmd.shu_step)
        begin
            ram_we    = pend_reg || shu_at_slot;
            ram_re    = !shu_at_slot;
            ram_raddr = idx_reg - addr_t'(1);
        end
        if (cmd.shd_step)
        begin
            ram_we    = pend_reg;
            ram_re    = shd_more;
            ram_raddr = idx_inc[AW-1:0];
        end
        if (cmd.scan_step)
        begin
            ram_re    = scan_more;
            ram_raddr = idx_reg;
        end
        if (cmd.bis_issue)
        begin
            ram_re    = 1'b1;
            ram_raddr = mid;
        end
        if (cmd.pop_issue)
        begin
            ram_re    = 1'b1;
            ram_raddr = count_reg - addr_t'(1);
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        wptr_next       = wptr_reg;
        cmd_next        = cmd_reg;
        item_next       = item_reg;
        status_next     = status_reg;
        res_next        = res_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_count_next  = out_count_reg;

        if (cmd.load)
        begin
            cmd_next      = in_command;
            item_next.x    = in_x;
            item_next.y    = in_y;
            item_next.key  = in_key;
            item_next.cost = in_cost;
            status_next   = ST_OK;
            res_next      = '0;
        end
        if (cmd.st_en)
        begin
            status_next = cmd.st_code;
        end
        if (cmd.ins_init)
        begin
            lo_next = '0;
            hi_next = count_reg;
        end
        if (cmd.bis_issue)
        begin
            mid_next = mid;
        end
        if (cmd.bis_cmp)
        begin
            if (item_reg.cost > rd_data.cost)
            begin
                hi_next = mid_reg;
            end
            else if (item_reg.cost < rd_data.cost)
            begin
                lo_next = (lo_reg == mid_reg) ? mid_reg + addr_t'(1) : mid_reg;
            end
            else
            begin
                lo_next = mid_reg;
                hi_next = mid_reg;
            end
        end
        if (cmd.shu_init)
        begin
            idx_next  = count_reg;
            pend_next = 1'b0;
        end
        if (cmd.shu_step)
        begin
            if (!shu_at_slot)
            begin
                wptr_next = idx_reg;
                idx_next  = idx_reg - addr_t'(1);
                pend_next = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
                if (!pend_reg)
                begin
                    count_next = count_reg + addr_t'(1);
                end
            end
        end
        if (cmd.scan_init)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            if (scan_more)
            begin
                wptr_next = idx_reg;
                idx_next  = idx_inc[AW-1:0];
                pend_next = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
        if (cmd.scan_take)
        begin
            item_next.x = rd_data.x;
            item_next.y = rd_data.y;
            idx_next    = wptr_reg;
            pend_next   = 1'b0;
        end
        if (cmd.shd_step)
        begin
            if (shd_more)
            begin
                wptr_next = idx_reg;
                idx_next  = idx_inc[AW-1:0];
                pend_next = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
                if (!pend_reg)
                begin
                    count_next = count_reg - addr_t'(1);
                end
            end
        end
        if (cmd.pop_take)
        begin
            res_next   = rd_data;
            count_next = count_reg - addr_t'(1);
        end
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_entry_next  = res_reg;
            out_count_next  = COUNT_W'(count_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        wptr_reg       <= wptr_next;
        cmd_reg        <= cmd_next;
        item_reg       <= item_next;
        status_reg     <= status_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_count_reg  <= out_count_next;
    end

    soq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_entry  = out_entry_reg;
    assign out_count  = out_count_reg;

endmodule

// ===== rtl/core/sorted_open_set_queue.sv =====
// Top level of the sorted open-set queue: controller, datapath and channel wiring.
// Depends on soq_pkg, soq_if, soq_ctrl and soq_datapath.
//
// The queue holds the open set of a best-first search in a RAM of DEPTH entries,
// kept sorted by descending cost so that the cheapest node sits at the tail. Every
// item transfer on the item channel gives exactly one result transfer on the result
// channel, in order. An insert into a set of n entries first finds its slot by
// bisection. Each bisection step is one RAM read and one compare, and the bisection
// needs at most ceil(log2(n)) + 1 steps. The entries at and above the slot then move
// up one place per cycle through the RAM's single read and single write port. An
// update scans keys one entry per cycle from the head, moves the entries behind a
// match, if any, down one place per cycle, then runs an insert. Items are worked on
// one at a time; a finished result waits in the output register while the next item
// is accepted and processed. The entry RAM needs no clearing after reset, as only
// filled places are ever read. The limit register is written through the cfg channel,
// which is always ready, and must only be written while no item is in flight.
module sorted_open_set_queue #(
    parameter int DEPTH = soq_pkg::DEPTH_DEFAULT
) (
    input logic      clk,
    input logic      rst_n,
    soq_in_if.sink   item,
    soq_out_if.source result,
    soq_cfg_if.sink  cfg
);
    import soq_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;
    entry_t  res_entry;

    // The limit register takes a write in any cycle.
    assign cfg.ready = 1'b1;

    soq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .cmd        (dp_cmd),
        .sts        (dp_sts)
    );

    soq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .sts        (dp_sts),
        .in_command (item.command),
        .in_x       (item.pos_x),
        .in_y       (item.pos_y),
        .in_key     (item.node_key),
        .in_cost    (item.total_cost),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.capacity_limit),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_status (result.status),
        .out_entry  (res_entry),
        .out_count  (result.entry_count)
    );

    // The result entry is zero unless the item was a successful pop.
    assign result.out_x    = res_entry.x;
    assign result.out_y    = res_entry.y;
    assign result.out_key  = res_entry.key;
    assign result.out_cost = res_entry.cost;

endmodule

// ===== rtl/core/soq_checker.sv =====
// Port-level checks for the sorted open-set queue, bound to its top level.
// Depends on soq_pkg and sorted_open_set_queue.
module soq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [soq_pkg::STATUS_W-1:0] result_status,
    input logic [soq_pkg::COST_W-1:0]   result_cost,
    input logic [soq_pkg::COUNT_W-1:0]  result_count
);
    import soq_pkg::*;

    logic               item_xfer;
    logic               result_xfer;
    logic [1:0]         pending_reg;
    logic [COUNT_W-1:0] last_count_reg;

    assign item_xfer   = item_valid && item_ready;
    assign result_xfer = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_count_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, item_xfer} - {1'b0, result_xfer};
            if (result_xfer)
            begin
                last_count_reg <= result_count;
            end
        end
    end

    // A held result keeps its count and cost until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_count)
            && $stable(result_cost))
        else $error("result changed while stalled");

    // Every result belongs to an accepted item.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 2'd0)
        else $error("result without an outstanding item");

    // With one result waiting and one item in work, no further item is taken.
    a_two_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> !item_ready)
        else $error("item accepted with two items outstanding");

    // The held count moves by at most one entry per item.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_xfer |-> (result_count == last_count_reg)
            || (result_count == last_count_reg + COUNT_W'(1))
            || (last_count_reg == result_count + COUNT_W'(1)))
        else $error("entry count jumped");

    // A pop on an empty set follows a result that left the set empty.
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        result_xfer && result_status == ST_EMPTY |-> result_count == '0
            && last_count_reg == '0 && result_cost == '0)
        else $error("empty pop reported with entries held");

endmodule

bind sorted_open_set_queue soq_checker u_soq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_status (result.status),
    .result_cost   (result.out_cost),
    .result_count  (result.entry_count)
);
